FILE: sv/radix_digit_converter_defines.svh
// Assertion macros for the converter modules, used by rdc_back.
`ifndef RADIX_DIGIT_CONVERTER_DEFINES_SVH
`define RADIX_DIGIT_CONVERTER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define RDC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rdc: same-cycle check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define RDC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rdc: next-cycle check failed");

`endif

FILE: sv/rdc_pkg.sv
package rdc_pkg;

  localparam int RADIX_W   = 4;
  localparam int DIGIT_W   = 4;
  localparam int STEP_BITS = 8;

  localparam logic [RADIX_W-1:0] RADIX_MIN   = 4'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX   = 4'd10;
  localparam logic [RADIX_W-1:0] RADIX_RESET = 4'd10;

  typedef struct packed {
    logic [RADIX_W-1:0] radix;
    logic               bad;
    logic               zero;
  } rdc_cls_t;

endpackage

FILE: sv/rdc_front.sv
module rdc_front #(
  parameter int VALUE_BITS = 31
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [rdc_pkg::RADIX_W-1:0]  cfg_data,
  input  logic                         push,
  output logic                         full,
  input  logic [VALUE_BITS-1:0]        value,
  output logic                         q_valid,
  input  logic                         q_pop,
  output logic [VALUE_BITS-1:0]        q_value,
  output rdc_pkg::rdc_cls_t            q_cls
);
  import rdc_pkg::*;

  logic [RADIX_W-1:0]    radix_r;
  logic [VALUE_BITS-1:0] val_q [2];
  rdc_cls_t              cls_q [2];
  logic                  wr_ptr_r, rd_ptr_r;
  logic [1:0]            cnt_r;
  logic                  wr_en, rd_en;
  rdc_cls_t              cls_in;

  assign cfg_ready = 1'b1;
  assign full      = (cnt_r == 2'd2);
  assign q_valid   = (cnt_r != 2'd0);
  assign wr_en     = push && !full;
  assign rd_en     = q_pop && q_valid;
  assign q_value   = val_q[rd_ptr_r];
  assign q_cls     = cls_q[rd_ptr_r];

  always_comb begin
    cls_in.radix = radix_r;
    cls_in.bad   = (radix_r < RADIX_MIN) || (radix_r > RADIX_MAX);
    cls_in.zero  = (value == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r  <= RADIX_RESET;
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (cfg_valid) begin
        radix_r <= cfg_data;
      end
      if (wr_en) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (rd_en) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      if (wr_en && !rd_en) begin
        cnt_r <= cnt_r + 2'd1;
      end else if (rd_en && !wr_en) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      val_q[wr_ptr_r] <= value;
      cls_q[wr_ptr_r] <= cls_in;
    end
  end

endmodule

FILE: sv/rdc_div.sv
module rdc_div #(
  parameter int VALUE_BITS = 31
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [VALUE_BITS-1:0]        dividend,
  input  logic [rdc_pkg::RADIX_W-1:0]  divisor,
  output logic                         done,
  output logic [VALUE_BITS-1:0]        quot,
  output logic [rdc_pkg::DIGIT_W-1:0]  rem
);
  import rdc_pkg::*;

  localparam int CHUNKS = (VALUE_BITS + STEP_BITS - 1) / STEP_BITS;
  localparam int PAD    = CHUNKS * STEP_BITS;
  localparam int CNT_W  = $clog2(CHUNKS + 1);

  logic [PAD-1:0]           work_r, work_nxt;
  logic [DIGIT_W-1:0]       rem_r, rem_nxt;
  logic [RADIX_W-1:0]       divisor_r;
  logic [CNT_W-1:0]         cnt_r, cnt_nxt;
  logic                     busy_r, busy_nxt;
  logic                     done_r, done_nxt;
  logic [STEP_BITS-1:0]     qbits;
  logic [DIGIT_W-1:0]       step_rem;
  logic [PAD+STEP_BITS-1:0] shifted;

  always_comb begin
    logic [DIGIT_W:0] t;
    step_rem = rem_r;
    qbits    = '0;
    for (int i = 0; i < STEP_BITS; i++) begin
      t = {step_rem, work_r[PAD-1-i]};
      if (t >= {1'b0, divisor_r}) begin
        t = t - {1'b0, divisor_r};
        qbits[STEP_BITS-1-i] = 1'b1;
      end
      step_rem = t[DIGIT_W-1:0];
    end
  end

  assign shifted = {work_r, qbits};

  always_comb begin
    work_nxt = work_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      work_nxt = PAD'(dividend);
      rem_nxt  = '0;
      cnt_nxt  = CNT_W'(CHUNKS);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      work_nxt = shifted[PAD-1:0];
      rem_nxt  = step_rem;
      cnt_nxt  = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    work_r <= work_nxt;
    rem_r  <= rem_nxt;
    if (start) begin
      divisor_r <= divisor;
    end
  end

  assign done = done_r;
  assign quot = work_r[VALUE_BITS-1:0];
  assign rem  = rem_r;

endmodule

FILE: sv/rdc_back.sv
`include "radix_digit_converter_defines.svh"

module rdc_back #(
  parameter int VALUE_BITS = 31
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         q_valid,
  output logic                         q_pop,
  input  logic [VALUE_BITS-1:0]        q_value,
  input  rdc_pkg::rdc_cls_t            q_cls,
  output logic                         out_empty,
  input  logic                         out_pop,
  output logic [rdc_pkg::DIGIT_W-1:0]  out_digit,
  output logic                         out_last,
  output logic                         out_bad_radix
);
  import rdc_pkg::*;

  localparam int IW = $clog2(VALUE_BITS);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV  = 2'd1;
  localparam logic [1:0] S_RD   = 2'd2;
  localparam logic [1:0] S_WR   = 2'd3;

  logic [1:0]            state_r, state_nxt;
  logic [RADIX_W-1:0]    radix_r, radix_nxt;
  logic [IW-1:0]         wr_idx_r, wr_idx_nxt;
  logic [IW-1:0]         idx_r, idx_nxt;
  logic                  single_r, single_nxt;
  logic                  bad_r, bad_nxt;
  logic [DIGIT_W-1:0]    digit_store [VALUE_BITS];
  logic [DIGIT_W-1:0]    mem_q_r;
  logic                  st_we, rd_en;
  logic                  div_start, div_done;
  logic [VALUE_BITS-1:0] div_dividend, div_quot;
  logic [RADIX_W-1:0]    div_radix;
  logic [DIGIT_W-1:0]    div_rem;
  logic                  out_valid_r;
  logic [DIGIT_W-1:0]    out_digit_r;
  logic                  out_last_r, out_bad_r;
  logic                  out_xfer, out_free, out_load;

  rdc_div #(.VALUE_BITS(VALUE_BITS)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_radix),
    .done     (div_done),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  assign out_xfer = out_pop && out_valid_r;
  assign out_free = !out_valid_r || out_xfer;

  always_comb begin
    state_nxt    = state_r;
    radix_nxt    = radix_r;
    wr_idx_nxt   = wr_idx_r;
    idx_nxt      = idx_r;
    single_nxt   = single_r;
    bad_nxt      = bad_r;
    q_pop        = 1'b0;
    div_start    = 1'b0;
    div_dividend = div_quot;
    div_radix    = radix_r;
    st_we        = 1'b0;
    rd_en        = 1'b0;
    out_load     = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          q_pop     = 1'b1;
          radix_nxt = q_cls.radix;
          bad_nxt   = q_cls.bad;
          if (q_cls.bad || q_cls.zero) begin
            single_nxt = 1'b1;
            idx_nxt    = '0;
            state_nxt  = S_WR;
          end else begin
            single_nxt   = 1'b0;
            wr_idx_nxt   = '0;
            div_start    = 1'b1;
            div_dividend = q_value;
            div_radix    = q_cls.radix;
            state_nxt    = S_DIV;
          end
        end
      end
      S_DIV: begin
        if (div_done) begin
          st_we      = 1'b1;
          wr_idx_nxt = wr_idx_r + 1'b1;
          if (div_quot == '0) begin
            idx_nxt   = wr_idx_r;
            state_nxt = S_RD;
          end else begin
            div_start = 1'b1;
          end
        end
      end
      S_RD: begin
        rd_en     = 1'b1;
        state_nxt = S_WR;
      end
      S_WR: begin
        if (out_free) begin
          out_load = 1'b1;
          if (idx_r == '0) begin
            state_nxt = S_IDLE;
          end else begin
            idx_nxt   = idx_r - 1'b1;
            state_nxt = S_RD;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (st_we) begin
      digit_store[wr_idx_r] <= div_rem;
    end
    if (rd_en) begin
      mem_q_r <= digit_store[idx_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_xfer) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    radix_r  <= radix_nxt;
    wr_idx_r <= wr_idx_nxt;
    idx_r    <= idx_nxt;
    single_r <= single_nxt;
    bad_r    <= bad_nxt;
    if (out_load) begin
      out_digit_r <= single_r ? '0 : mem_q_r;
      out_last_r  <= (idx_r == '0);
      out_bad_r   <= bad_r;
    end
  end

  assign out_empty     = !out_valid_r;
  assign out_digit     = out_digit_r;
  assign out_last      = out_last_r;
  assign out_bad_radix = out_bad_r;

  `RDC_ASSERT_NOW(a_done_in_div, div_done, state_r == S_DIV)
  `RDC_ASSERT_NEXT(a_final_last, out_load && (idx_r == '0), out_valid_r && out_last_r)
  `RDC_ASSERT_NOW(a_bad_single, out_valid_r && out_bad_r, (out_digit_r == '0) && out_last_r)

endmodule

FILE: sv/radix_digit_converter.sv
// Converts each pushed non-negative integer (low VALUE_BITS bits of in_value) into digits of
// the radix held in the cfg register (reset 10) and pops them most significant first, with
// out_last on the final digit. A radix outside 2..10 gives one result with out_bad_radix set,
// digit 0; a zero value gives one digit 0. A two-entry input queue takes items while the
// converter works. Each digit is one division by a shared divider that retires 8 dividend bits
// per cycle and returns its result through a registered done; then come one read of the digit
// store and one output load per digit. A zero value or a bad radix needs no division.
// The radix is sampled when an item is pushed.
module radix_digit_converter #(
  parameter int VALUE_BITS = 31
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [rdc_pkg::RADIX_W-1:0]  cfg_data,
  input  logic                         push,
  output logic                         full,
  input  logic [VALUE_BITS-1:0]        in_value,
  output logic                         empty,
  input  logic                         pop,
  output logic [rdc_pkg::DIGIT_W-1:0]  out_digit,
  output logic                         out_last,
  output logic                         out_bad_radix
);
  import rdc_pkg::*;

  logic                  q_valid, q_pop;
  logic [VALUE_BITS-1:0] q_value;
  rdc_cls_t              q_cls;

  rdc_front #(.VALUE_BITS(VALUE_BITS)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .push      (push),
    .full      (full),
    .value     (in_value),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_value   (q_value),
    .q_cls     (q_cls)
  );

  rdc_back #(.VALUE_BITS(VALUE_BITS)) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_valid       (q_valid),
    .q_pop         (q_pop),
    .q_value       (q_value),
    .q_cls         (q_cls),
    .out_empty     (empty),
    .out_pop       (pop),
    .out_digit     (out_digit),
    .out_last      (out_last),
    .out_bad_radix (out_bad_radix)
  );

endmodule

FILE: tb/radix_digit_converter_tb.sv
`timescale 1ns / 1ps

module radix_digit_converter_tb;
  import rdc_pkg::*;

  localparam int VALUE_BITS     = 31;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int TAIL_CYCLES    = 300;
  localparam int PHASES         = 18;
  localparam int ITEMS_PER_PHASE = 26;

  typedef struct packed {
    logic [DIGIT_W-1:0] digit;
    logic               is_last;
    logic               bad;
  } digit_result_t;

  typedef struct packed {
    logic [RADIX_W-1:0]    radix;
    logic [VALUE_BITS-1:0] value;
    logic                  typed;
    digit_result_t         result;
  } directed_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [RADIX_W-1:0]    cfg_data = '0;
  logic                  push = 1'b0;
  logic                  full;
  logic [VALUE_BITS-1:0] in_value = '0;
  logic                  empty;
  logic                  pop = 1'b0;
  logic [DIGIT_W-1:0]    out_digit;
  logic                  out_last;
  logic                  out_bad_radix;

  digit_result_t      expected_digits[$];
  logic [DIGIT_W-1:0] digit_store [VALUE_BITS];
  logic [RADIX_W-1:0] model_radix = RADIX_RESET;
  int                 error_count = 0;
  int                 stall_cycles = 0;
  int                 send_idle = 22;
  int                 recv_idle = 68;

  localparam digit_result_t ZERO_DIGIT = '{digit: 4'd0, is_last: 1'b1, bad: 1'b0};
  localparam digit_result_t BAD_RESULT = '{digit: 4'd0, is_last: 1'b1, bad: 1'b1};
  localparam digit_result_t NO_TYPED   = '{digit: 4'd0, is_last: 1'b0, bad: 1'b0};

  directed_row_t directed_rows [20] = '{
    '{4'd10, 31'd0,          1'b1, ZERO_DIGIT},
    '{4'd10, 31'd7,          1'b1, '{4'd7, 1'b1, 1'b0}},
    '{4'd10, 31'd9,          1'b1, '{4'd9, 1'b1, 1'b0}},
    '{4'd10, 31'd10,         1'b0, NO_TYPED},
    '{4'd10, 31'h7FFF_FFFF,  1'b0, NO_TYPED},
    '{4'd10, 31'd1000000000, 1'b0, NO_TYPED},
    '{4'd2,  31'd1,          1'b1, '{4'd1, 1'b1, 1'b0}},
    '{4'd2,  31'd0,          1'b1, ZERO_DIGIT},
    '{4'd2,  31'h7FFF_FFFF,  1'b0, NO_TYPED},
    '{4'd2,  31'h4000_0000,  1'b0, NO_TYPED},
    '{4'd2,  31'h2AAA_AAAA,  1'b0, NO_TYPED},
    '{4'd3,  31'd2,          1'b1, '{4'd2, 1'b1, 1'b0}},
    '{4'd3,  31'h7FFF_FFFF,  1'b0, NO_TYPED},
    '{4'd9,  31'd8,          1'b1, '{4'd8, 1'b1, 1'b0}},
    '{4'd7,  31'd48,         1'b0, NO_TYPED},
    '{4'd0,  31'd123,        1'b1, BAD_RESULT},
    '{4'd1,  31'd0,          1'b1, BAD_RESULT},
    '{4'd11, 31'h7FFF_FFFF,  1'b1, BAD_RESULT},
    '{4'd15, 31'd5,          1'b1, BAD_RESULT},
    '{4'd10, 31'd0,          1'b1, ZERO_DIGIT}
  };

  radix_digit_converter #(.VALUE_BITS(VALUE_BITS)) dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .push         (push),
    .full         (full),
    .in_value     (in_value),
    .empty        (empty),
    .pop          (pop),
    .out_digit    (out_digit),
    .out_last     (out_last),
    .out_bad_radix(out_bad_radix)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic void predict_digits(logic [RADIX_W-1:0] base, logic [VALUE_BITS-1:0] value);
    logic [VALUE_BITS-1:0] rest;
    int                    n;
    if (base < RADIX_MIN || base > RADIX_MAX) begin
      expected_digits.push_back(BAD_RESULT);
      return;
    end
    rest = value;
    n = 0;
    while (rest != 0 && n < VALUE_BITS) begin
      digit_store[n] = DIGIT_W'(rest % base);
      rest = rest / base;
      n++;
    end
    if (n == 0) begin
      expected_digits.push_back(ZERO_DIGIT);
      return;
    end
    for (int k = n - 1; k >= 0; k--) begin
      expected_digits.push_back(digit_result_t'{digit_store[k], k == 0, 1'b0});
    end
  endfunction

  function automatic logic [VALUE_BITS-1:0] pick_value(logic [RADIX_W-1:0] base);
    int          kind;
    int          steps;
    longint      power;
    logic [31:0] raw;
    kind = $urandom_range(99);
    raw = $urandom;
    if (kind < 30) return raw[VALUE_BITS-1:0];
    if (kind < 55) return VALUE_BITS'(raw >> $urandom_range(31, 1));
    if (kind < 75) return VALUE_BITS'($urandom_range(99));
    if (kind < 90) begin
      power = 1;
      steps = $urandom_range(30, 1);
      for (int i = 0; i < steps; i++) begin
        if (power * ((base < 2) ? 10 : base) < (64'd1 << VALUE_BITS))
          power = power * ((base < 2) ? 10 : base);
      end
      return VALUE_BITS'(power - $urandom_range(1));
    end
    return raw[0] ? '1 : '0;
  endfunction

  // Call just after a falling edge; returns just after a falling edge with push still high.
  task automatic push_value(logic [VALUE_BITS-1:0] value, logic typed, digit_result_t result);
    while ($urandom_range(99) < send_idle) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push <= 1'b1;
    in_value <= value;
    do @(posedge clk); while (full);
    if (typed) expected_digits.push_back(result);
    else predict_digits(model_radix, value);
    @(negedge clk);
  endtask

  // Drain all results, then write the radix.
  task automatic set_radix(logic [RADIX_W-1:0] base);
    push <= 1'b0;
    while (expected_digits.size() != 0) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= base;
    do @(posedge clk); while (!cfg_ready);
    model_radix = base;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  always @(negedge clk) begin
    pop <= rst_n && ($urandom_range(99) >= recv_idle);
  end

  always @(posedge clk) begin
    if (rst_n && pop && !empty) begin
      if (expected_digits.size() == 0) begin
        error_count++;
        if (error_count <= 10)
          $display("unexpected result: digit=%0d last=%0b bad_radix=%0b",
                   out_digit, out_last, out_bad_radix);
      end else begin
        if (out_digit !== expected_digits[0].digit || out_last !== expected_digits[0].is_last ||
            out_bad_radix !== expected_digits[0].bad) begin
          error_count++;
          if (error_count <= 10)
            $display("mismatch: expected digit=%0d last=%0b bad_radix=%0b,",
                     expected_digits[0].digit, expected_digits[0].is_last, expected_digits[0].bad,
                     " got digit=%0d last=%0b bad_radix=%0b",
                     out_digit, out_last, out_bad_radix);
        end
        void'(expected_digits.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
  end

  initial begin : watchdog
    wait (stall_cycles >= WATCHDOG_LIMIT);
    $display("Some tests failed");
    $finish;
  end

  initial begin
    logic [RADIX_W-1:0] base;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].radix != model_radix) set_radix(directed_rows[i].radix);
      push_value(directed_rows[i].value, directed_rows[i].typed, directed_rows[i].result);
    end

    for (int p = 0; p < PHASES; p++) begin
      if (p == PHASES / 3) begin
        send_idle = 68;
        recv_idle = 22;
      end else if (p == 2 * PHASES / 3) begin
        send_idle = 0;
        recv_idle = 0;
      end
      case (p)
        0: base = 4'd2;
        1: base = 4'd10;
        2: base = 4'd0;
        3: base = 4'd15;
        4: base = 4'd3;
        5: base = 4'd1;
        6: base = 4'd11;
        7: base = 4'd7;
        default: begin
          if ($urandom_range(99) < 20) base = $urandom_range(1) ? RADIX_W'($urandom_range(1))
                                                                : RADIX_W'($urandom_range(15, 11));
          else base = RADIX_W'($urandom_range(RADIX_MAX, RADIX_MIN));
        end
      endcase
      set_radix(base);
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        push_value(pick_value(model_radix), 1'b0, NO_TYPED);
      end
    end

    push <= 1'b0;
    while (expected_digits.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (error_count == 0 && expected_digits.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
